FILE: hdl/radix_digit_converter_core_assert.svh
// ----------------------------------------------------------------------------
// Radix digit converter - assertion macros
// Shared property forms for the checker of the radix digit converter.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdc checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rdc checker: next-cycle property failed");

`endif

FILE: hdl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit converter - package
// Shared widths, types, reciprocal table and digit encoding.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int MAX_DIGITS  = 31;
    localparam int RADIX_W     = 6;
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = VALUE_BITS + RECIP_W;
    localparam int CHAR_W      = 7;
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IN_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((CHAR_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd429496729;

    localparam logic [RADIX_W-1:0] DIGIT_LETTER_MIN = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_LETTER_MAX = 6'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_G     = 7'h47;
    localparam logic [CHAR_W-1:0] ASCII_SLASH = 7'h2F;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  is_zero;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [RECIP_W-1:0] recip;
    } t_cfg;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_MUL,
        BACK_FIX,
        BACK_EMIT
    } t_back_state;

    // Clamp a written base into the supported range.
    function automatic logic [RADIX_W-1:0] radix_sat(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    // floor(2^32 / radix); the quotient estimate from it is exact or one low.
    function automatic logic [RECIP_W-1:0] radix_recip(input logic [RADIX_W-1:0] r);
        case (r)
            6'd2:    return 32'd2147483648;
            6'd3:    return 32'd1431655765;
            6'd4:    return 32'd1073741824;
            6'd5:    return 32'd858993459;
            6'd6:    return 32'd715827882;
            6'd7:    return 32'd613566756;
            6'd8:    return 32'd536870912;
            6'd9:    return 32'd477218588;
            6'd10:   return 32'd429496729;
            6'd11:   return 32'd390451572;
            6'd12:   return 32'd357913941;
            6'd13:   return 32'd330382099;
            6'd14:   return 32'd306783378;
            6'd15:   return 32'd286331153;
            6'd16:   return 32'd268435456;
            6'd17:   return 32'd252645135;
            6'd18:   return 32'd238609294;
            6'd19:   return 32'd226050910;
            6'd20:   return 32'd214748364;
            6'd21:   return 32'd204522252;
            6'd22:   return 32'd195225786;
            6'd23:   return 32'd186737708;
            6'd24:   return 32'd178956970;
            6'd25:   return 32'd171798691;
            6'd26:   return 32'd165191049;
            6'd27:   return 32'd159072862;
            6'd28:   return 32'd153391689;
            6'd29:   return 32'd148102320;
            6'd30:   return 32'd143165576;
            6'd31:   return 32'd138547332;
            6'd32:   return 32'd134217728;
            6'd33:   return 32'd130150524;
            6'd34:   return 32'd126322567;
            6'd35:   return 32'd122713351;
            6'd36:   return 32'd119304647;
            default: return RECIP_RESET;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        if (d > DIGIT_LETTER_MAX) begin
            return ASCII_SLASH;
        end else if (d >= DIGIT_LETTER_MIN) begin
            return ASCII_A + CHAR_W'(d - DIGIT_LETTER_MIN);
        end
        return ASCII_ZERO + CHAR_W'(d);
    endfunction

endpackage

FILE: hdl/rdc_front.sv
// ----------------------------------------------------------------------------
// Radix digit converter - front end
// Accepts input values, tags zero and holds them in a short queue.
// ----------------------------------------------------------------------------
module rdc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tvalid,
    output logic                        o_tready,
    input  logic [rdc_pkg::IN_DATA_W-1:0] i_tdata,   // [30:0] value, [31] unused
    output rdc_pkg::t_q2b               o_q,
    input  logic                        i_pop
);
    import rdc_pkg::*;

    t_item               r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QFILL_W-1:0]  r_fill,   n_fill;
    logic                push;
    logic                pop;
    t_item               in_item;

    assign o_tready = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign push     = i_tvalid && o_tready;
    assign pop      = i_pop && (r_fill != '0);

    always_comb begin
        in_item.value   = i_tdata[VALUE_BITS-1:0];
        in_item.is_zero = (i_tdata[VALUE_BITS-1:0] == '0);
        o_q.valid       = (r_fill != '0);
        o_q.item        = r_buf[r_rd_ptr];
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= in_item;
        end
    end

endmodule

FILE: hdl/rdc_back.sv
// ----------------------------------------------------------------------------
// Radix digit converter - back end
// Divides by the base one digit at a time, then streams the digits out.
// ----------------------------------------------------------------------------
module rdc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rdc_pkg::t_cfg              i_cfg,
    input  rdc_pkg::t_q2b              i_q,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [rdc_pkg::CHAR_W-1:0] o_char,
    output logic                       o_last
);
    import rdc_pkg::*;

    t_back_state           r_state, n_state;
    logic [VALUE_BITS-1:0] r_quot,  n_quot;
    logic [PROD_W-1:0]     r_prod,  n_prod;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_idx,   n_idx;
    logic [RADIX_W-1:0]    r_store [MAX_DIGITS];
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char,  n_out_char;
    logic                  r_out_last,  n_out_last;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [RADIX_W-1:0]    wr_data;
    logic [VALUE_BITS-1:0] q_est;
    logic [2*CHAR_W-1:0]   low_prod;
    logic [CHAR_W-1:0]     rem_raw;
    logic                  rem_over;
    logic [VALUE_BITS-1:0] q_fix;
    logic [RADIX_W-1:0]    d_fix;
    logic                  out_free;

    // The remainder is below twice the base, so seven low bits settle it.
    always_comb begin
        q_est    = r_prod[PROD_W-1:RECIP_W];
        low_prod = (2*CHAR_W)'(q_est[CHAR_W-1:0]) * (2*CHAR_W)'(i_cfg.radix);
        rem_raw  = r_quot[CHAR_W-1:0] - low_prod[CHAR_W-1:0];
        rem_over = (rem_raw >= CHAR_W'(i_cfg.radix));
        q_fix    = rem_over ? q_est + 1'b1 : q_est;
        d_fix    = rem_over ? RADIX_W'(rem_raw - CHAR_W'(i_cfg.radix)) : RADIX_W'(rem_raw);
    end

    assign out_free = !r_out_valid || i_tready;

    always_comb begin
        n_state     = r_state;
        n_quot      = r_quot;
        n_prod      = r_prod;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_count[IDX_W-1:0];
        wr_data     = d_fix;
        case (r_state)
            BACK_IDLE: begin
                if (i_q.valid) begin
                    o_pop  = 1'b1;
                    n_quot = i_q.item.value;
                    if (i_q.item.is_zero) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = '0;
                        n_count = CNT_W'(1);
                        n_idx   = '0;
                        n_state = BACK_EMIT;
                    end else begin
                        n_count = '0;
                        n_state = BACK_MUL;
                    end
                end
            end
            BACK_MUL: begin
                n_prod  = PROD_W'(r_quot) * PROD_W'(i_cfg.recip);
                n_state = BACK_FIX;
            end
            BACK_FIX: begin
                wr_en   = 1'b1;
                n_quot  = q_fix;
                n_count = r_count + 1'b1;
                if ((q_fix == '0) || (n_count == CNT_W'(MAX_DIGITS))) begin
                    n_idx   = r_count[IDX_W-1:0];
                    n_state = BACK_EMIT;
                end else begin
                    n_state = BACK_MUL;
                end
            end
            BACK_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_to_ascii(r_store[r_idx]);
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = BACK_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BACK_IDLE;
            r_quot      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_quot      <= n_quot;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_char   = r_out_char;
    assign o_last   = r_out_last;

endmodule

FILE: hdl/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// Radix digit converter - top level
// Converts non-negative integers to ASCII digit strings in a set base.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction carries one 31-bit value in tdata.
//   Master stream: one transaction per digit character, most significant
//   first; tlast marks the least significant digit. Zero gives one '0'.
//   Config channel: writes the base; values below 2 or above 36 are
//   clamped. Write only while no conversion is in flight.
// Timing:
//   Each digit takes two steps in the shared divide unit (reciprocal
//   multiply, then remainder fix-up); once all digits are found, the
//   characters stream out one per cycle while the receiver takes them.
//   Zero skips the divide and gives its single '0' directly. A two-entry
//   queue lets values be accepted while the back end is busy.
// Reset: queue emptied, output invalid, base back to 10.
// Stall: the output register holds its character until taken and the
//   back end waits; the input side keeps filling the queue.
// ----------------------------------------------------------------------------
module radix_digit_converter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [rdc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // [30:0] value, [31] unused
    // output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [rdc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // [6:0] digit_char, [7] zero pad
    output logic                           o_m_axis_tlast,  // last
    // base register write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rdc_pkg::RADIX_W-1:0]    i_cfg_data       // [5:0] radix
);
    import rdc_pkg::*;

    // Base and its reciprocal, held together so the divide unit needs no table.
    t_cfg               r_cfg;
    t_q2b               q2b;
    logic               pop;
    logic [CHAR_W-1:0]  out_char;
    logic [RADIX_W-1:0] cfg_sat;

    assign o_cfg_ready = 1'b1;
    assign cfg_sat     = radix_sat(i_cfg_data);

    // Clamp the written base and load the matching reciprocal.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix <= RADIX_RESET;
            r_cfg.recip <= RECIP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg.radix <= cfg_sat;
            r_cfg.recip <= radix_recip(cfg_sat);
        end
    end

    // Front: accept and tag values, queue them for the divide unit.
    rdc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .o_q      (q2b),
        .i_pop    (pop)
    );

    // Back: divide digit by digit, then stream characters out.
    rdc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q      (q2b),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_char   (out_char),
        .o_last   (o_m_axis_tlast)
    );

    // Pad the character up to a whole byte.
    assign o_m_axis_tdata = OUT_DATA_W'(out_char);

endmodule

FILE: hdl/rdc_checker.sv
// ----------------------------------------------------------------------------
// Radix digit converter - port checker
// Watches the output stream for protocol and digit string rules.
// ----------------------------------------------------------------------------
`include "radix_digit_converter_core_assert.svh"

module rdc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [rdc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                           o_m_axis_tlast
);
    import rdc_pkg::*;

    // High while the next character would open a new digit string.
    logic r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_start <= o_m_axis_tlast;
        end
    end

    `RDC_ASSERT_NEXT(a_out_valid_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `RDC_ASSERT_NEXT(a_out_data_hold, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
    `RDC_ASSERT_SAME(a_char_legal, o_m_axis_tvalid, (o_m_axis_tdata >= OUT_DATA_W'(ASCII_ZERO) && o_m_axis_tdata <= OUT_DATA_W'(ASCII_NINE)) || (o_m_axis_tdata >= OUT_DATA_W'(ASCII_A) && o_m_axis_tdata <= OUT_DATA_W'(ASCII_G)) || (o_m_axis_tdata == OUT_DATA_W'(ASCII_SLASH)))
    `RDC_ASSERT_SAME(a_no_leading_zero, o_m_axis_tvalid && r_start && (o_m_axis_tdata == OUT_DATA_W'(ASCII_ZERO)), o_m_axis_tlast)

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

FILE: dv/radix_digit_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter - testbench
// Sends values over the input stream, checks every digit character and its
// tlast against a predicted string for the current base, and rewrites the
// base between phases. The receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [rdc_pkg::CHAR_W-1:0] digit_char;
    logic                       last;
} t_digit_exp;

// Predicts the digit string of each accepted value and checks the characters.
class digit_scoreboard;
    logic [rdc_pkg::RADIX_W-1:0] base;
    t_digit_exp                  pending_chars[$];
    int unsigned                 mismatches;

    function new();
        base        = rdc_pkg::RADIX_RESET;
        mismatches  = 0;
    endfunction

    // Clamp the written base into 2..36.
    function void set_radix(input logic [rdc_pkg::RADIX_W-1:0] raw);
        if (raw < 6'd2) begin
            base = 6'd2;
        end else if (raw > 6'd36) begin
            base = 6'd36;
        end else begin
            base = raw;
        end
    endfunction

    function logic [rdc_pkg::CHAR_W-1:0] char_of(input logic [rdc_pkg::RADIX_W-1:0] d);
        if (d > 6'd16) begin
            return rdc_pkg::ASCII_SLASH;
        end else if (d >= 6'd10) begin
            return rdc_pkg::ASCII_A + 7'(d - 6'd10);
        end
        return rdc_pkg::ASCII_ZERO + 7'(d);
    endfunction

    // Divide repeatedly; the most significant digit ends up at the front.
    function void note_value(input logic [rdc_pkg::IN_DATA_W-1:0] word);
        logic [rdc_pkg::VALUE_BITS-1:0] quot;
        logic [rdc_pkg::RADIX_W-1:0]    digits[$];
        t_digit_exp                     e;
        int                             n;
        quot = word[rdc_pkg::VALUE_BITS-1:0];
        do begin
            digits.push_front(6'(quot % base));
            quot = quot / base;
        end while (quot != 0 && digits.size() < rdc_pkg::MAX_DIGITS);
        n = digits.size();
        for (int k = 0; k < n; k++) begin
            e.digit_char = char_of(digits[k]);
            e.last       = (k == n - 1);
            pending_chars.push_back(e);
        end
    endfunction

    function void flag(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endfunction

    function void check_char(input logic [rdc_pkg::CHAR_W-1:0] got_char, input logic got_last);
        t_digit_exp e;
        if (pending_chars.size() == 0) begin
            flag($sformatf("unexpected char %h last %b", got_char, got_last));
            return;
        end
        e = pending_chars.pop_front();
        if (got_char !== e.digit_char || got_last !== e.last) begin
            flag($sformatf("expected char %h last %b, got char %h last %b",
                           e.digit_char, e.last, got_char, got_last));
        end
    endfunction

    // Count characters that never turned up and return the failure total.
    function int unsigned close_out();
        if (pending_chars.size() != 0) begin
            flag($sformatf("%0d expected characters never arrived", pending_chars.size()));
        end
        return mismatches;
    endfunction
endclass

module radix_digit_converter_core_tb;
    import rdc_pkg::*;

    localparam int PRESSURE_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 50;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata  = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                    o_m_axis_tlast;
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [RADIX_W-1:0]      i_cfg_data      = '0;

    int unsigned             tx_idle_pct     = 0;
    int unsigned             rx_idle_pct     = 0;
    int unsigned             hold_request    = 0;

    digit_scoreboard         sb = new();

    radix_digit_converter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** radix_digit_converter_core: FAILED **");
        $finish;
    end

    // Observe every transaction at the rising edge, where inputs are settled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_radix(i_cfg_data);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_value(i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_char(o_m_axis_tdata[CHAR_W-1:0], o_m_axis_tlast);
            end
        end
    end

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [IN_DATA_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Drop the input valid and hold until every predicted character is out.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Base writes go in only while the converter is idle.
    task automatic write_radix(input logic [RADIX_W-1:0] raw);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mix of zero, full scale, powers of the base (and one below) and
    // random widths; now and then set the pad bit, which must be ignored.
    function automatic logic [IN_DATA_W-1:0] random_word();
        logic [63:0]          pw;
        logic [63:0]          mask;
        logic [IN_DATA_W-1:0] w;
        int unsigned          n;
        case ($urandom_range(9))
            0: w = '0;
            1: w = {1'b0, {VALUE_BITS{1'b1}}};
            2, 3: begin
                pw = 64'd1;
                n  = $urandom_range(1, 31);
                repeat (n) begin
                    if (pw * sb.base < (64'd1 << VALUE_BITS)) begin
                        pw = pw * sb.base;
                    end
                end
                w = IN_DATA_W'($urandom_range(1) ? pw : pw - 64'd1);
            end
            default: begin
                mask = (64'd1 << $urandom_range(1, VALUE_BITS)) - 64'd1;
                w    = IN_DATA_W'({32'd0, $urandom} & mask);
            end
        endcase
        w[IN_DATA_W-1] = ($urandom_range(7) == 0);
        return w;
    endfunction

    initial begin
        logic [RADIX_W-1:0] plan[6];
        logic [RADIX_W-1:0] raw;
        plan = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd17, 6'd1};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 10;
        rx_idle_pct = 86;

        // Decimal straight out of reset, with full scale and the pad bit.
        send_word(32'd0);
        send_word(32'd1);
        send_word(32'd9);
        send_word(32'd10);
        send_word(32'd2147483647);
        send_word(32'd1000000000);
        send_word({1'b1, 31'd12345});
        send_word(32'hFFFF_FFFF);

        // Binary: the longest string the field allows.
        write_radix(6'd2);
        send_word(32'd0);
        send_word(32'd1);
        send_word(32'h7FFF_FFFF);
        send_word(32'h4000_0000);
        send_word(32'h5555_5555);

        // Base 36: digits above sixteen become slashes.
        write_radix(6'd36);
        send_word(32'd35);
        send_word(32'd36);
        send_word(32'd16);
        send_word(32'd17);
        send_word(32'd1295);
        send_word(32'h7FFF_FFFF);

        // Base 17: the top letter digit.
        write_radix(6'd17);
        send_word(32'd16);
        send_word(32'd288);

        // Out-of-range bases clamp to the nearest end.
        write_radix(6'd0);
        send_word(32'd5);
        write_radix(6'd1);
        send_word(32'd6);
        write_radix(6'd37);
        send_word(32'd100);
        write_radix(6'd63);
        send_word(32'd1000);

        for (int phase = 0; phase < 9; phase++) begin
            raw = (phase < 6) ? plan[phase] : RADIX_W'($urandom_range(0, 63));
            write_radix(raw);
            case (phase / 3)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 86;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // Block the output for a long stretch while values keep coming,
            // so the queue fills and the input stalls.
            if (phase == 6) begin
                hold_request = PRESSURE_CYCLES;
            end
            repeat (ITEMS_PER_PHASE) begin
                send_word(random_word());
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.close_out() == 0) begin
            $display("** radix_digit_converter_core: PASSED **");
        end else begin
            $display("** radix_digit_converter_core: FAILED **");
        end
        $finish;
    end
endmodule
